// ===== design/pbcg_pkg.sv =====
// Shared types and constants for the pixel brightness/contrast/gamma unit.
package pbcg_pkg;

  localparam logic [7:0]  MID_LEVEL   = 8'd128;
  localparam logic [7:0]  FULL_LEVEL  = 8'd255;
  localparam logic [9:0]  PERCENT     = 10'd100;
  localparam logic [9:0]  RESET_PCT   = 10'd100;
  // 128*b/100 == (b*5243) >> 12 exactly for b < 1024
  localparam logic [12:0] OFFSET_MUL  = 13'd5243;
  localparam int          OFFSET_SHR  = 12;
  localparam logic [10:0] OFFSET_RST  = 11'd128;
  // x/100 == (x*167773) >> 24 exactly for x < 2^17
  localparam logic [17:0] RECIP_100   = 18'd167773;
  localparam int          RECIP_SHR   = 24;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_CONTRAST   = 2'd1,
    CFG_GAMMA      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic       func;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] entry_index;
    logic [7:0] entry_value;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pixel_out_t;

  // load enables for the two arithmetic stages
  typedef struct packed {
    logic ld1;
    logic ld2;
  } stage_en_t;

endpackage

// ===== design/pbcg_chan.sv =====
// One color channel: contrast multiply, divide by 100, offset add and clamp.
module pbcg_chan (
  input  logic                clk,
  input  pbcg_pkg::stage_en_t en,
  input  logic [7:0]          chan_in,
  input  logic [9:0]          contrast,
  input  logic [10:0]         offset,
  output logic [7:0]          level
);
  import pbcg_pkg::*;

  logic signed [8:0]  centered;
  logic signed [19:0] prod;
  logic [17:0]        pabs;
  logic [17:0]        pabs_r;
  logic               neg1_r;
  logic [35:0]        quot_full;
  logic [10:0]        quot_r;
  logic               neg2_r;
  logic signed [12:0] sum;

  always_comb begin
    centered = $signed({1'b0, chan_in} - {1'b0, MID_LEVEL});
    prod     = $signed({1'b0, contrast}) * centered;
    pabs     = prod[19] ? 18'(-prod) : prod[17:0];
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      pabs_r <= pabs;
      neg1_r <= prod[19];
    end
  end

  // truncating divide of the magnitude, sign reapplied below
  assign quot_full = pabs_r * RECIP_100;

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      quot_r <= quot_full[RECIP_SHR+10:RECIP_SHR];
      neg2_r <= neg1_r;
    end
  end

  always_comb begin
    if (neg2_r) begin
      sum = $signed({2'b00, offset}) - $signed({2'b00, quot_r});
    end else begin
      sum = $signed({2'b00, offset}) + $signed({2'b00, quot_r});
    end
    if (sum >= $signed({5'd0, FULL_LEVEL})) begin
      level = FULL_LEVEL;
    end else if (sum <= 13'sd0) begin
      level = 8'd0;
    end else begin
      level = sum[7:0];
    end
  end

endmodule

// ===== design/pixel_brightness_contrast_gamma_unit.sv =====
// Top level: pixel brightness/contrast/gamma pipeline with gamma table memories.
// A pixel is registered at stage 1, stage 2, then out_valid; stalls hold it longer.
// One item per cycle unless stalled; a table write takes its slot but gives no result.
// Each channel: multiply stage, divide-by-reciprocal stage, then clamp and table read
// into the output register. The table is held twice (two read ports plus one).
// Reset: percent registers go to 100, pipeline empties; table contents stay undefined.
module pixel_brightness_contrast_gamma_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pbcg_pkg::pixel_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pbcg_pkg::pixel_out_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [9:0]           cfg_data
);
  import pbcg_pkg::*;

  logic [9:0]  contrast_r;
  logic [9:0]  gamma_r;
  logic [10:0] offset_r;
  logic [22:0] offset_prod;

  logic        v1_r, v2_r, out_valid_r;
  logic        func1_r, func2_r;
  logic [7:0]  idx1_r, idx2_r, val1_r, val2_r;
  logic        adv_o, adv2, adv1, in_acc, wr_en;
  stage_en_t   st_en;

  logic [7:0]  lvl_r, lvl_g, lvl_b;
  logic [7:0]  lvl_r_r, lvl_g_r, lvl_b_r;
  logic        tab_r_r, tab_g_r, tab_b_r;
  logic        gamma_on;
  logic [7:0]  rd_r_r, rd_g_r, rd_b_r;

  logic [7:0]  tab_a_mem [256];
  logic [7:0]  tab_b_mem [256];

  // configuration
  assign cfg_ready   = 1'b1;
  assign offset_prod = cfg_data * OFFSET_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r <= RESET_PCT;
      gamma_r    <= RESET_PCT;
      offset_r   <= OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BRIGHTNESS: offset_r   <= offset_prod[OFFSET_SHR+10:OFFSET_SHR];
        CFG_CONTRAST:   contrast_r <= cfg_data;
        CFG_GAMMA:      gamma_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage advance, bubbles collapse under back-pressure
  assign adv_o     = !out_valid_r || !out_stall;
  assign adv2      = !v2_r || adv_o;
  assign adv1      = !v1_r || adv2;
  assign in_stall  = !adv1;
  assign in_acc    = in_valid && adv1;
  assign st_en.ld1 = adv1;
  assign st_en.ld2 = adv2;
  assign wr_en     = v2_r && func2_r && adv_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_acc;
      if (adv2) v2_r <= v1_r;
      if (adv_o) out_valid_r <= v2_r && !func2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      func1_r <= in_data.func;
      idx1_r  <= in_data.entry_index;
      val1_r  <= in_data.entry_value;
    end
    if (adv2) begin
      func2_r <= func1_r;
      idx2_r  <= idx1_r;
      val2_r  <= val1_r;
    end
  end

  pbcg_chan u_chan_r (
    .clk(clk), .en(st_en), .chan_in(in_data.red_in),
    .contrast(contrast_r), .offset(offset_r), .level(lvl_r)
  );
  pbcg_chan u_chan_g (
    .clk(clk), .en(st_en), .chan_in(in_data.green_in),
    .contrast(contrast_r), .offset(offset_r), .level(lvl_g)
  );
  pbcg_chan u_chan_b (
    .clk(clk), .en(st_en), .chan_in(in_data.blue_in),
    .contrast(contrast_r), .offset(offset_r), .level(lvl_b)
  );

  // table writes happen in item order at the read stage, so no forwarding needed
  always_ff @(posedge clk) begin
    if (wr_en) tab_a_mem[idx2_r] <= val2_r;
    if (adv_o) begin
      rd_r_r <= tab_a_mem[lvl_r];
      rd_g_r <= tab_a_mem[lvl_g];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) tab_b_mem[idx2_r] <= val2_r;
    if (adv_o) rd_b_r <= tab_b_mem[lvl_b];
  end

  assign gamma_on = (gamma_r != PERCENT);

  always_ff @(posedge clk) begin
    if (adv_o) begin
      lvl_r_r <= lvl_r;
      lvl_g_r <= lvl_g;
      lvl_b_r <= lvl_b;
      tab_r_r <= gamma_on && (lvl_r != 8'd0) && (lvl_r != FULL_LEVEL);
      tab_g_r <= gamma_on && (lvl_g != 8'd0) && (lvl_g != FULL_LEVEL);
      tab_b_r <= gamma_on && (lvl_b != 8'd0) && (lvl_b != FULL_LEVEL);
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_data.red_out   = tab_r_r ? rd_r_r : lvl_r_r;
    out_data.green_out = tab_g_r ? rd_g_r : lvl_g_r;
    out_data.blue_out  = tab_b_r ? rd_b_r : lvl_b_r;
  end

endmodule

// ===== design/pbcg_chk.sv =====
// Port-level checks for the pixel brightness/contrast/gamma unit, bound to the top.
module pbcg_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input pbcg_pkg::pixel_out_t out_data
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // input back-pressure only ever comes from a stalled output item
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output item changed while stalled");

endmodule

bind pixel_brightness_contrast_gamma_unit pbcg_chk u_pbcg_chk (.*);

// ===== tb/pbcg_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the pixel brightness/contrast/gamma unit: predicts and checks adjusted pixels.
package pbcg_tb_pkg;
  import pbcg_pkg::*;

  class pixel_adjust_scoreboard;
    localparam int MID = 128;
    localparam int PCT = 100;
    localparam int FULL = 255;
    localparam int MAX_REPORTS = 10;

    logic [9:0] bright;
    logic [9:0] contrast;
    logic [9:0] gamma;
    logic [7:0] gamma_lut [256];
    pixel_out_t pending_pixels [$];
    int errors;

    function new();
      bright = RESET_PCT;
      contrast = RESET_PCT;
      gamma = RESET_PCT;
      foreach (gamma_lut[i]) gamma_lut[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [9:0] val);
      case (idx)
        CFG_BRIGHTNESS: bright = val;
        CFG_CONTRAST:   contrast = val;
        CFG_GAMMA:      gamma = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] adjust_level(logic [7:0] v);
      int centered;
      int scaled;
      int offset;
      int sum;
      int c;
      int b;
      logic [7:0] level;
      c = contrast;
      b = bright;
      centered = v;
      centered = centered - MID;
      // int division truncates toward zero on both quotients
      scaled = (c * centered) / PCT;
      offset = (MID * b) / PCT;
      sum = scaled + offset;
      if (sum >= FULL) level = 8'(FULL);
      else if (sum <= 0) level = 8'd0;
      else level = 8'(sum);
      // black and white bypass the table
      if (gamma != 10'(PCT) && level != 8'd0 && level != 8'(FULL)) level = gamma_lut[level];
      return level;
    endfunction

    function void note_item(pixel_in_t it);
      pixel_out_t px;
      if (it.func) begin
        gamma_lut[it.entry_index] = it.entry_value;
      end else begin
        px.red_out = adjust_level(it.red_in);
        px.green_out = adjust_level(it.green_in);
        px.blue_out = adjust_level(it.blue_in);
        pending_pixels.push_back(px);
      end
    endfunction

    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected pixel r=%0d g=%0d b=%0d",
                   got.red_out, got.green_out, got.blue_out);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red_out, want.green_out, want.blue_out,
                   got.red_out, got.green_out, got.blue_out);
      end
    endfunction
  endclass

endpackage

// ===== tb/pixel_brightness_contrast_gamma_unit_test.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the pixel brightness/contrast/gamma unit.
module pixel_brightness_contrast_gamma_unit_test;
  import pbcg_pkg::*;
  import pbcg_tb_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  pixel_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pixel_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_BRIGHTNESS;
  logic [9:0] cfg_data = '0;

  pixel_adjust_scoreboard sb;
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;

  pixel_brightness_contrast_gamma_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_data);
  end

  // receiver: random stall bursts, free runs, one long hold on request
  initial begin : receiver
    int stall_left;
    int free_left;
    int hold_left;
    stall_left = 0;
    free_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 7) - 1;
        free_left = $urandom_range(0, 40);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("pixel_brightness_contrast_gamma_unit regression: fail");
    $finish;
  end

  function automatic pixel_in_t pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_in_t it;
    it.func = 1'b0;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    it.entry_index = 8'($urandom_range(0, 255));
    it.entry_value = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic pixel_in_t table_write(logic [7:0] idx, logic [7:0] val);
    pixel_in_t it;
    it.func = 1'b1;
    it.red_in = 8'($urandom_range(0, 255));
    it.green_in = 8'($urandom_range(0, 255));
    it.blue_in = 8'($urandom_range(0, 255));
    it.entry_index = idx;
    it.entry_value = val;
    return it;
  endfunction

  // mostly uniform, sometimes a level at a clamp or around mid gray
  function automatic logic [7:0] pick_level();
    logic [7:0] corners [7];
    corners = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pixel_in_t random_item(int write_pct);
    if ($urandom_range(0, 99) < write_pct)
      return table_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    return pixel(pick_level(), pick_level(), pick_level());
  endfunction

  // leaves in_valid high so a following item goes out back to back
  task automatic send_item(pixel_in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic send_after_gap(pixel_in_t it, int gap_pct);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    send_item(it);
  endtask

  task automatic run_items(int count, int write_pct, int gap_pct);
    for (int n = 0; n < count; n++) send_after_gap(random_item(write_pct), gap_pct);
  endtask

  task automatic send_corners();
    send_item(pixel(8'd0, 8'd128, 8'd255));
    send_item(pixel(8'd1, 8'd127, 8'd254));
    send_item(pixel(8'd129, 8'd2, 8'd253));
  endtask

  // table writes give no result, so wait out the pipe after the last pixel
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_settings(logic [9:0] b, logic [9:0] c, logic [9:0] g);
    write_reg(CFG_BRIGHTNESS, b);
    write_reg(CFG_CONTRAST, c);
    write_reg(CFG_GAMMA, g);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_random_settings();
    logic [9:0] b;
    logic [9:0] c;
    logic [9:0] g;
    b = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(40, 250));
    c = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 400));
    g = ($urandom_range(0, 3) == 0) ? PERCENT : 10'($urandom_range(1, 1000));
    apply_settings(b, c, g);
  endtask

  initial begin : stimulus
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // neutral settings after reset: pixels pass through unchanged
    send_corners();
    send_item(pixel(8'd255, 8'd0, 8'd128));
    send_item(table_write(8'd0, 8'h5a));
    send_item(table_write(8'd255, 8'ha5));

    // fill every entry the lookup can reach before gamma leaves 100
    for (int i = 1; i <= 254; i++)
      send_after_gap(table_write(8'(i), 8'($urandom_range(0, 255))), 15);
    drain();

    apply_settings(10'd0, 10'd0, 10'd1);
    send_corners();
    run_items(50, 10, 20);
    drain();

    apply_settings(10'd1023, 10'd1023, 10'd1023);
    send_corners();
    run_items(50, 10, 20);
    drain();

    // gamma 0 still goes through the table
    apply_settings(PERCENT, PERCENT, 10'd0);
    send_corners();
    run_items(50, 10, 0);
    drain();

    // receiver holds off while items keep coming, so the pipe backs up
    apply_settings(10'd120, 10'd250, 10'd180);
    long_hold_req = 1'b1;
    run_items(60, 10, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      apply_random_settings();
      run_items(55, 10, ($urandom_range(0, 1) == 0) ? 0 : 25);
      drain();
    end

    calm = 1'b1;
    apply_random_settings();
    run_items(50, 10, 0);
    drain();

    if (sb.errors == 0 && sb.pending_pixels.size() == 0)
      $display("pixel_brightness_contrast_gamma_unit regression: pass");
    else
      $display("pixel_brightness_contrast_gamma_unit regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pbcg_pkg.sv
design/pbcg_chan.sv
design/pixel_brightness_contrast_gamma_unit.sv
design/pbcg_chk.sv
tb/pbcg_tb_pkg.sv
tb/pixel_brightness_contrast_gamma_unit_test.sv
